[rtl/motion_record_reverse_playback_assert.svh]
// ----------------------------------------------------------------------------
// Motion record and reverse playback: assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOTION_RECORD_REVERSE_PLAYBACK_ASSERT_SVH
`define MOTION_RECORD_REVERSE_PLAYBACK_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MRRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// Consequence that must hold in the cycle after the trigger.
`define MRRP_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define MRRP_ASSERT(label, clk, rst_n, prop, msg)
`define MRRP_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)
`endif

`endif

[rtl/mrrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion record and reverse playback package
// Shared types, codes and constants of the record and playback block.
// ----------------------------------------------------------------------------
package mrrp_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 32;
	localparam int unsigned SHADOW_DEPTH_DEF  = 1024;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [7:0]  throttle;
		logic [7:0]  steer;
	} sample_t;

	localparam int unsigned SAMPLE_W = $bits(sample_t);

	typedef enum logic [1:0] {
		MODE_RECORD = 2'd0,
		MODE_REWIND = 2'd1,
		MODE_HOME   = 2'd2,
		MODE_STEP   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_NONE    = 2'd0,
		STAT_BRAKE   = 2'd1,
		STAT_PLAY    = 2'd2,
		STAT_REFUSED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_CUR,
		ST_RD_PREV,
		ST_EXEC
	} state_t;

	localparam logic [7:0]  THR_FULL       = 8'd180;
	localparam logic [7:0]  THR_NEUTRAL    = 8'd90;
	localparam logic [7:0]  THR_BRAKE      = 8'd60;
	localparam logic [9:0]  BRAKE_HOLD_MS  = 10'd50;
	localparam logic [9:0]  INTERVAL_RESET = 10'd100;
	localparam logic [31:0] GAP_LIMIT_MS   = 32'd500;
	localparam logic [1:0]  BRAKE_STEPS    = 2'd3;
	localparam logic [1:0]  BRAKE_HARD     = 2'd1;

endpackage

[rtl/mrrp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module mrrp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/motion_record_reverse_playback.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion record and reverse playback
// Records steer/throttle samples in two ring RAMs and plays them back in reverse.
// ----------------------------------------------------------------------------
// Usage: items arrive on the input channel (in_valid / in_stall), one result
// per item leaves on the output channel (out_valid / out_stall). Mode 0 records
// a sample, modes 1 and 2 start a rewind of the short history or of the long
// shadow store, mode 3 steps playback: three brake commands, then the stored
// samples from newest down to the second oldest, which only sets a hold time.
// Sequence: a record, start, idle step or brake step passes through transfer,
// then execute. A playback step passes through transfer, two reads and execute:
// the current and the next older sample are read one after the other through the
// single read port of the chosen RAM, and the hold time is worked out from both.
// The input is taken again as soon as the block is back in idle, even while a
// result still sits in the output register; execution of that item then waits
// until the receiver takes the earlier result. A stalled result stays unchanged.
// After reset both stores count as empty and the interval register reads 100.
// The sample RAMs need no clearing: only written entries are ever played back.
// cfg_wr_en writes the fallback hold interval; do so only while the block is idle.
// ----------------------------------------------------------------------------
`include "motion_record_reverse_playback_assert.svh"

module motion_record_reverse_playback
	import mrrp_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int unsigned SHADOW_DEPTH  = SHADOW_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_wr_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  steer,
	input  logic [7:0]  throttle,
	input  logic [31:0] time_ms,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  steer_cmd,
	output logic        steer_valid,
	output logic [7:0]  throttle_cmd,
	output logic [9:0]  hold_ms,
	output logic        last
);

	localparam int unsigned HAW = $clog2(HISTORY_DEPTH);
	localparam int unsigned SAW = $clog2(SHADOW_DEPTH);
	localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned SCW = $clog2(SHADOW_DEPTH + 1);
	localparam int unsigned OW  = (HCW > SCW) ? HCW : SCW;
	localparam int unsigned WW  = OW + 1;

	localparam logic [WW-1:0] H_DEPTH_W = WW'(HISTORY_DEPTH);
	localparam logic [WW-1:0] S_DEPTH_W = WW'(SHADOW_DEPTH);

	state_t state_q, state_d;

	// Accepted item
	logic [1:0]  mode_q;
	logic [7:0]  steer_q;
	logic [7:0]  throttle_q;
	logic [31:0] time_q;

	logic [9:0]     interval_q;
	logic [HAW-1:0] hist_head_q;
	logic [HCW-1:0] hist_cnt_q;
	logic [SAW-1:0] shad_head_q;
	logic [SCW-1:0] shad_cnt_q;
	logic           rewind_active_q;
	logic           rewind_kind_q;
	logic [1:0]     brake_phase_q;
	logic [OW-1:0]  play_off_q;
	sample_t        samp_cur_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  steer_cmd_q;
	logic        steer_valid_q;
	logic [7:0]  throttle_cmd_q;
	logic [9:0]  hold_q;
	logic        last_q;

	logic in_xfer, out_free, out_load, play_read;

	// Ring addresses of the current and next older sample
	logic [WW-1:0]  hist_cur_w, hist_prev_w, shad_cur_w, shad_prev_w;
	logic [WW-1:0]  hist_cur_m, hist_prev_m, shad_cur_m, shad_prev_m;
	logic [HAW-1:0] hist_rd_addr;
	logic [SAW-1:0] shad_rd_addr;
	logic           hist_rd_en, shad_rd_en, store_wr_en;
	sample_t        hist_rd_data, shad_rd_data, samp_prev, samp_wr;

	logic [31:0] gap;
	logic [9:0]  gap_sel;
	logic [WW-1:0] play_cnt_w;
	logic        is_last, start_low;

	status_t     res_status;
	logic [7:0]  res_steer, res_thr;
	logic        res_sval, res_last;
	logic [9:0]  res_hold;
	logic        do_record, do_start, do_brake, do_play;

	assign hist_cur_w  = WW'(hist_head_q) + H_DEPTH_W - WW'(1) - WW'(play_off_q);
	assign hist_prev_w = WW'(hist_head_q) + H_DEPTH_W - WW'(2) - WW'(play_off_q);
	assign shad_cur_w  = WW'(shad_head_q) + S_DEPTH_W - WW'(1) - WW'(play_off_q);
	assign shad_prev_w = WW'(shad_head_q) + S_DEPTH_W - WW'(2) - WW'(play_off_q);

	assign hist_cur_m  = (hist_cur_w  >= H_DEPTH_W) ? hist_cur_w  - H_DEPTH_W : hist_cur_w;
	assign hist_prev_m = (hist_prev_w >= H_DEPTH_W) ? hist_prev_w - H_DEPTH_W : hist_prev_w;
	assign shad_cur_m  = (shad_cur_w  >= S_DEPTH_W) ? shad_cur_w  - S_DEPTH_W : shad_cur_w;
	assign shad_prev_m = (shad_prev_w >= S_DEPTH_W) ? shad_prev_w - S_DEPTH_W : shad_prev_w;

	assign hist_rd_addr = (state_q == ST_RD_CUR) ? hist_cur_m[HAW-1:0] : hist_prev_m[HAW-1:0];
	assign shad_rd_addr = (state_q == ST_RD_CUR) ? shad_cur_m[SAW-1:0] : shad_prev_m[SAW-1:0];

	assign samp_wr = '{time_ms: time_q, throttle: throttle_q, steer: steer_q};

	mrrp_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (store_wr_en),
		.wr_addr (hist_head_q),
		.wr_data (samp_wr),
		.rd_en   (hist_rd_en),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rd_data)
	);

	mrrp_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (SHADOW_DEPTH)
	) u_shad_ram (
		.clk     (clk),
		.wr_en   (store_wr_en),
		.wr_addr (shad_head_q),
		.wr_data (samp_wr),
		.rd_en   (shad_rd_en),
		.rd_addr (shad_rd_addr),
		.rd_data (shad_rd_data)
	);

	// The older sample's read data is held by the RAM while the result waits.
	assign samp_prev = rewind_kind_q ? shad_rd_data : hist_rd_data;

	assign gap        = samp_cur_q.time_ms - samp_prev.time_ms;
	assign gap_sel    = (gap > GAP_LIMIT_MS) ? interval_q : gap[9:0];
	assign play_cnt_w = rewind_kind_q ? WW'(shad_cnt_q) : WW'(hist_cnt_q);
	assign is_last    = (WW'(play_off_q) + WW'(2)) >= play_cnt_w;
	assign start_low  = (mode_q == MODE_HOME) ? (shad_cnt_q < SCW'(2)) : (hist_cnt_q < HCW'(2));

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign play_read = (mode_t'(mode) == MODE_STEP) && rewind_active_q &&
	                   (brake_phase_q == BRAKE_STEPS);

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		out_load    = 1'b0;
		hist_rd_en  = 1'b0;
		shad_rd_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = play_read ? ST_RD_CUR : ST_EXEC;
				end
			end
			ST_RD_CUR: begin
				hist_rd_en = !rewind_kind_q;
				shad_rd_en = rewind_kind_q;
				state_d    = ST_RD_PREV;
			end
			ST_RD_PREV: begin
				hist_rd_en = !rewind_kind_q;
				shad_rd_en = rewind_kind_q;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res_status = STAT_NONE;
		res_steer  = '0;
		res_sval   = 1'b0;
		res_thr    = '0;
		res_hold   = '0;
		res_last   = 1'b0;
		do_record  = 1'b0;
		do_start   = 1'b0;
		do_brake   = 1'b0;
		do_play    = 1'b0;
		case (mode_t'(mode_q))
			MODE_RECORD: begin
				do_record = !rewind_active_q;
			end
			MODE_REWIND, MODE_HOME: begin
				if (!rewind_active_q) begin
					if (start_low) begin
						res_status = STAT_REFUSED;
					end else begin
						do_start = 1'b1;
					end
				end
			end
			MODE_STEP: begin
				if (rewind_active_q) begin
					if (brake_phase_q != BRAKE_STEPS) begin
						do_brake   = 1'b1;
						res_status = STAT_BRAKE;
						res_thr    = (brake_phase_q == BRAKE_HARD) ? THR_BRAKE : THR_NEUTRAL;
						res_hold   = BRAKE_HOLD_MS;
					end else begin
						do_play    = 1'b1;
						res_status = STAT_PLAY;
						res_steer  = samp_cur_q.steer;
						res_sval   = 1'b1;
						res_thr    = (samp_cur_q.throttle > THR_FULL) ? 8'd0 :
						             THR_FULL - samp_cur_q.throttle;
						res_hold   = rewind_kind_q ? {1'b0, gap_sel[9:1]} : gap_sel;
						res_last   = is_last;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign store_wr_en = out_load && do_record;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q      <= INTERVAL_RESET;
			hist_head_q     <= '0;
			hist_cnt_q      <= '0;
			shad_head_q     <= '0;
			shad_cnt_q      <= '0;
			rewind_active_q <= 1'b0;
			rewind_kind_q   <= 1'b0;
			brake_phase_q   <= '0;
			play_off_q      <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				interval_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load && do_record) begin
				hist_head_q <= (hist_head_q == HAW'(HISTORY_DEPTH - 1)) ? '0 :
				               hist_head_q + HAW'(1);
				shad_head_q <= (shad_head_q == SAW'(SHADOW_DEPTH - 1)) ? '0 :
				               shad_head_q + SAW'(1);
				if (hist_cnt_q < HCW'(HISTORY_DEPTH)) begin
					hist_cnt_q <= hist_cnt_q + HCW'(1);
				end
				if (shad_cnt_q < SCW'(SHADOW_DEPTH)) begin
					shad_cnt_q <= shad_cnt_q + SCW'(1);
				end
			end
			if (out_load && do_start) begin
				rewind_active_q <= 1'b1;
				rewind_kind_q   <= (mode_q == MODE_HOME);
				brake_phase_q   <= '0;
				play_off_q      <= '0;
			end
			if (out_load && do_brake) begin
				brake_phase_q <= brake_phase_q + 2'd1;
			end
			if (out_load && do_play) begin
				if (is_last) begin
					// End of playback: the played store counts as empty again.
					rewind_active_q <= 1'b0;
					brake_phase_q   <= '0;
					play_off_q      <= '0;
					if (rewind_kind_q) begin
						shad_cnt_q  <= '0;
						shad_head_q <= '0;
					end else begin
						hist_cnt_q <= '0;
					end
				end else begin
					play_off_q <= play_off_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q     <= mode;
			steer_q    <= steer;
			throttle_q <= throttle;
			time_q     <= time_ms;
		end
		if (state_q == ST_RD_PREV) begin
			samp_cur_q <= samp_prev;
		end
		if (out_load) begin
			status_q       <= res_status;
			steer_cmd_q    <= res_steer;
			steer_valid_q  <= res_sval;
			throttle_cmd_q <= res_thr;
			hold_q         <= res_hold;
			last_q         <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign steer_cmd    = steer_cmd_q;
	assign steer_valid  = steer_valid_q;
	assign throttle_cmd = throttle_cmd_q;
	assign hold_ms      = hold_q;
	assign last         = last_q;

	`MRRP_ASSERT(a_hist_cnt_range, clk, arst_n, hist_cnt_q <= HCW'(HISTORY_DEPTH), "history count beyond depth")
	`MRRP_ASSERT(a_shad_cnt_range, clk, arst_n, shad_cnt_q <= SCW'(SHADOW_DEPTH), "shadow count beyond depth")
	`MRRP_ASSERT(a_active_has_samples, clk, arst_n, !rewind_active_q || (rewind_kind_q ? (shad_cnt_q >= SCW'(2)) : (hist_cnt_q >= HCW'(2))), "rewind active on a store with fewer than two samples")
	`MRRP_ASSERT(a_read_in_playback, clk, arst_n, !(state_q == ST_RD_CUR || state_q == ST_RD_PREV) || (rewind_active_q && brake_phase_q == BRAKE_STEPS), "sample read outside playback")
	`MRRP_ASSERT_NEXT(a_last_ends_rewind, clk, arst_n, out_load && do_play && is_last, !rewind_active_q && play_off_q == '0, "rewind still active after final command")

endmodule

[tb/sv/mrrp_command_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion record and reverse playback: command checker
// Watches the configuration port and both channels of the block, works out
// the command due for every accepted input transfer and compares each
// accepted output transfer, field by field, with the oldest command due.
// ----------------------------------------------------------------------------
module mrrp_command_checker
	import mrrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_wr_data,

	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  steer,
	input  logic [7:0]  throttle,
	input  logic [31:0] time_ms,

	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [7:0]  steer_cmd,
	input  logic        steer_valid,
	input  logic [7:0]  throttle_cmd,
	input  logic [9:0]  hold_ms,
	input  logic        last,

	output int          n_pending,
	output int          n_errors,
	output int          n_checked
);

	typedef struct packed {
		status_t     status;
		logic [7:0]  steer_cmd;
		logic        steer_valid;
		logic [7:0]  throttle_cmd;
		logic [9:0]  hold_ms;
		logic        last;
	} command_t;

	sample_t     hist_mem [HISTORY_DEPTH_DEF];
	sample_t     shad_mem [SHADOW_DEPTH_DEF];
	logic [4:0]  hist_head;
	logic [5:0]  hist_fill;
	logic [9:0]  shad_head;
	logic [10:0] shad_fill;
	logic        playing;
	logic        from_shadow;
	logic [1:0]  brake_step;
	int unsigned play_pos;
	logic [9:0]  interval_ms;

	command_t    due_commands [$];
	int          err_total;
	int          checked_total;

	function automatic command_t next_command(mode_t op, logic [7:0] st, logic [7:0] th,
		logic [31:0] ts);
		command_t    cmd;
		sample_t     cur;
		sample_t     prv;
		logic [31:0] gap;
		int unsigned depth;
		int unsigned head;
		int unsigned fill;
		int unsigned ci;
		int unsigned pi;
		cmd = '0;
		if (op == MODE_RECORD) begin
			if (!playing) begin
				hist_mem[hist_head] = '{time_ms: ts, throttle: th, steer: st};
				shad_mem[shad_head] = '{time_ms: ts, throttle: th, steer: st};
				hist_head = hist_head + 1'b1;
				shad_head = shad_head + 1'b1;
				if (hist_fill < HISTORY_DEPTH_DEF)
					hist_fill = hist_fill + 1'b1;
				if (shad_fill < SHADOW_DEPTH_DEF)
					shad_fill = shad_fill + 1'b1;
			end
		end else if (op == MODE_REWIND || op == MODE_HOME) begin
			if (!playing) begin
				fill = (op == MODE_HOME) ? shad_fill : hist_fill;
				if (fill < 2) begin
					cmd.status = STAT_REFUSED;
				end else begin
					playing = 1'b1;
					from_shadow = (op == MODE_HOME);
					brake_step = '0;
					play_pos = 0;
				end
			end
		end else if (playing) begin
			if (brake_step < BRAKE_STEPS) begin
				cmd.status = STAT_BRAKE;
				cmd.throttle_cmd = (brake_step == BRAKE_HARD) ? THR_BRAKE : THR_NEUTRAL;
				cmd.hold_ms = BRAKE_HOLD_MS;
				brake_step = brake_step + 1'b1;
			end else begin
				depth = from_shadow ? SHADOW_DEPTH_DEF : HISTORY_DEPTH_DEF;
				head = from_shadow ? shad_head : hist_head;
				fill = from_shadow ? shad_fill : hist_fill;
				// Newest sample first; the one just older gives the hold time.
				ci = (head + 2 * depth - 1 - play_pos) % depth;
				pi = (head + 2 * depth - 2 - play_pos) % depth;
				cur = from_shadow ? shad_mem[ci] : hist_mem[ci];
				prv = from_shadow ? shad_mem[pi] : hist_mem[pi];
				gap = cur.time_ms - prv.time_ms;
				if (gap > GAP_LIMIT_MS)
					gap = interval_ms;
				if (from_shadow)
					gap = gap >> 1;
				cmd.status = STAT_PLAY;
				cmd.steer_cmd = cur.steer;
				cmd.steer_valid = 1'b1;
				cmd.throttle_cmd = (cur.throttle > THR_FULL) ? 8'd0 : THR_FULL - cur.throttle;
				cmd.hold_ms = gap[9:0];
				if (play_pos + 2 >= fill) begin
					cmd.last = 1'b1;
					playing = 1'b0;
					brake_step = '0;
					play_pos = 0;
					if (from_shadow) begin
						shad_fill = '0;
						shad_head = '0;
					end else begin
						hist_fill = '0;
					end
				end else begin
					play_pos = play_pos + 1;
				end
			end
		end
		return cmd;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		command_t due;
		if (!arst_n) begin
			hist_head = '0;
			hist_fill = '0;
			shad_head = '0;
			shad_fill = '0;
			playing = 1'b0;
			from_shadow = 1'b0;
			brake_step = '0;
			play_pos = 0;
			interval_ms = INTERVAL_RESET;
			due_commands.delete();
			err_total = 0;
			checked_total = 0;
			n_pending <= 0;
			n_errors <= 0;
			n_checked <= 0;
		end else begin
			if (cfg_wr_en)
				interval_ms = cfg_wr_data;
			// A result always comes out after its own item has been taken, so the
			// output side is dealt with before the input side.
			if (out_valid && !out_stall) begin
				if (due_commands.size() == 0) begin
					$error("output transfer with no command due: status %0d", status);
					err_total++;
				end else begin
					due = due_commands.pop_front();
					check_field("status", due.status, status);
					check_field("steer_cmd", due.steer_cmd, steer_cmd);
					check_field("steer_valid", due.steer_valid, steer_valid);
					check_field("throttle_cmd", due.throttle_cmd, throttle_cmd);
					check_field("hold_ms", due.hold_ms, hold_ms);
					check_field("last", due.last, last);
					checked_total++;
				end
			end
			if (in_valid && !in_stall)
				due_commands.push_back(next_command(mode_t'(mode), steer, throttle, time_ms));
			n_pending <= due_commands.size();
			n_errors <= err_total;
			n_checked <= checked_total;
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion record and reverse playback: testbench top
// Drives recording runs, rewinds, return-home requests and playback steps in
// random bursts against a receiver that stalls on its own pattern, changes
// the interval register between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import mrrp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ACTED_TARGET = 950;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [9:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = '0;
	logic [7:0]  steer = '0;
	logic [7:0]  throttle = '0;
	logic [31:0] time_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [7:0]  steer_cmd;
	logic        steer_valid;
	logic [7:0]  throttle_cmd;
	logic [9:0]  hold_ms;
	logic        last;

	int n_pending;
	int n_errors;
	int n_checked;

	// Rough fill levels, kept only to shape well-formed playback runs.
	int          hist_fill;
	int          shad_fill;
	bit          playing;
	bit          home_play;
	int          steps_left;
	int          burst_left;
	int          sent;
	int          acted;
	int          refusals;
	int          cfg_writes;
	int          cycle_count;
	logic [31:0] clock_ms;
	int          stall_style;
	int          stall_left;

	motion_record_reverse_playback u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.steer        (steer),
		.throttle     (throttle),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.steer_cmd    (steer_cmd),
		.steer_valid  (steer_valid),
		.throttle_cmd (throttle_cmd),
		.hold_ms      (hold_ms),
		.last         (last)
	);

	mrrp_command_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.steer        (steer),
		.throttle     (throttle),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.steer_cmd    (steer_cmd),
		.steer_valid  (steer_valid),
		.throttle_cmd (throttle_cmd),
		.hold_ms      (hold_ms),
		.last         (last),
		.n_pending    (n_pending),
		.n_errors     (n_errors),
		.n_checked    (n_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, n_pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// The receiver switches between no stalls, light stalls and heavy stalls.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			default: out_stall <= ($urandom_range(0, 99) < 75);
		endcase
	end

	task automatic send_item(mode_t op, logic [7:0] st, logic [7:0] th, logic [31:0] ts);
		int gap;
		int fill;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= op;
		steer <= st;
		throttle <= th;
		time_ms <= ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		case (op)
			MODE_RECORD: begin
				if (!playing) begin
					acted++;
					if (hist_fill < HISTORY_DEPTH_DEF)
						hist_fill++;
					if (shad_fill < SHADOW_DEPTH_DEF)
						shad_fill++;
				end
			end
			MODE_REWIND, MODE_HOME: begin
				if (!playing) begin
					acted++;
					fill = (op == MODE_HOME) ? shad_fill : hist_fill;
					if (fill >= 2) begin
						playing = 1'b1;
						home_play = (op == MODE_HOME);
						steps_left = fill + 2;
					end else begin
						refusals++;
					end
				end
			end
			default: begin
				if (playing) begin
					acted++;
					steps_left--;
					if (steps_left == 0) begin
						playing = 1'b0;
						if (home_play)
							shad_fill = 0;
						else
							hist_fill = 0;
					end
				end
			end
		endcase
	endtask

	task automatic record_sample();
		int r;
		logic [7:0] st;
		logic [7:0] th;
		r = $urandom_range(0, 99);
		if (r < 60)
			clock_ms += $urandom_range(1, 500);
		else if (r < 68)
			clock_ms += 500;
		else if (r < 74)
			clock_ms += 501;
		else if (r < 84)
			clock_ms += $urandom_range(501, 200000);
		else if (r < 95 && r >= 90)
			clock_ms = $urandom();
		else if (r >= 95)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
		st = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 180)) :
			8'($urandom_range(0, 255));
		th = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 180)) :
			8'($urandom_range(0, 255));
		send_item(MODE_RECORD, st, th, clock_ms);
	endtask

	task automatic send_noise();
		send_item(mode_t'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()), $urandom());
	endtask

	// Lets every outstanding result arrive before anything else happens.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_interval(logic [9:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_writes++;
	endtask

	initial begin
		int pick;
		int n;
		int next_cfg;
		int cfg_phase;
		logic [9:0] value;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle step and refusals on empty or nearly empty stores.
		send_item(MODE_STEP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(MODE_REWIND, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(MODE_HOME, 8'h00, 8'h00, 32'h0);
		send_item(MODE_RECORD, 8'd0, 8'd0, 32'd1000);
		send_item(MODE_REWIND, 8'h00, 8'h00, 32'h0);
		// Gaps of exactly 500 and 501, a gap far beyond the limit and one across
		// the timestamp wrap; throttles above full scale saturate to zero.
		send_item(MODE_RECORD, 8'd180, 8'd180, 32'd1500);
		send_item(MODE_RECORD, 8'd90, 8'd255, 32'd2001);
		send_item(MODE_RECORD, 8'd255, 8'd200, 32'hFFFF_FFF8);
		send_item(MODE_RECORD, 8'd37, 8'd181, 32'h0000_0008);
		send_item(MODE_REWIND, 8'h00, 8'h00, 32'h0);
		// A second start and a record during the rewind are both ignored.
		send_item(MODE_HOME, 8'h00, 8'h00, 32'h0);
		send_item(MODE_RECORD, 8'd12, 8'd34, 32'd9);
		repeat (7)
			send_item(MODE_STEP, 8'($urandom()), 8'($urandom()), $urandom());
		send_item(MODE_STEP, 8'h00, 8'h00, 32'h0);
		clock_ms = 32'd8;

		next_cfg = acted;
		cfg_phase = 0;
		while (acted < ACTED_TARGET + 20) begin
			if (!playing && acted >= next_cfg) begin
				case (cfg_phase % 4)
					0: value = 10'd1000;
					1: value = 10'd1;
					2: value = 10'($urandom_range(2, 999));
					default: value = 10'd500;
				endcase
				set_interval(value);
				cfg_phase++;
				next_cfg = acted + 150;
			end
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				if (pick < 8)
					n = $urandom_range(0, 1);
				else if (pick < 18)
					n = $urandom_range(30, 40);
				else
					n = $urandom_range(2, 8);
				repeat (n)
					record_sample();
				send_item(($urandom_range(0, 9) < 6) ? MODE_REWIND : MODE_HOME,
					8'($urandom()), 8'($urandom()), $urandom());
				while (playing) begin
					if ($urandom_range(0, 9) == 0)
						send_noise();
					else
						send_item(MODE_STEP, 8'($urandom()), 8'($urandom()), $urandom());
				end
			end else begin
				send_noise();
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("Sent %0d transfers (%0d acted on, %0d starts refused), %0d interval writes.",
			sent, acted, refusals, cfg_writes);
		$display("Checked %0d results, %0d mismatches or stray results.", n_checked, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
